@@ rtl/ifrd_pkg.sv @@
// Shared types and constants for the I-frame receive deframer.
// No dependencies; used by iframe_receive_deframer_core.
package ifrd_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BYTE_FLAG       = 8'h7E;
  localparam logic [7:0] BYTE_ESCAPE     = 8'h7D;
  localparam logic [7:0] ADDR_SENDER     = 8'h03;
  localparam logic [7:0] CTRL_SEQ0       = 8'h00;
  localparam logic [7:0] CTRL_SEQ1       = 8'h40;
  localparam logic [7:0] CTRL_DISCONNECT = 8'h0B;
  localparam logic [7:0] CTRL_RR0        = 8'h05;
  localparam logic [7:0] CTRL_RR1        = 8'h85;
  localparam logic [7:0] CTRL_REJ0       = 8'h01;
  localparam logic [7:0] CTRL_REJ1       = 8'h81;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EVENT   = 1'b1;

  localparam logic [2:0] STATUS_ACCEPTED   = 3'd0;
  localparam logic [2:0] STATUS_CHECK_ERR  = 3'd1;
  localparam logic [2:0] STATUS_DUPLICATE  = 3'd2;
  localparam logic [2:0] STATUS_EMPTY      = 3'd3;
  localparam logic [2:0] STATUS_DISCONNECT = 3'd4;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [2:0]       status;
    logic             reply_valid;
    logic [7:0]       reply_control;
    logic [LEN_W-1:0] payload_length;
    logic             last;
  } result_t;

  // one-byte-late release path of the payload
  typedef struct packed {
    logic             valid;
    logic [7:0]       data;
    logic [7:0]       bcc;
    logic [LEN_W-1:0] count;
  } hold_t;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

  function automatic hold_t hold_push(hold_t h, logic [7:0] b);
    hold_t r;
    r = h;
    if (h.valid) begin
      r.bcc = h.bcc ^ h.data;
      if (h.count < LEN_MAX) begin
        r.count = h.count + LEN_W'(1);
      end
    end
    r.data  = b;
    r.valid = 1'b1;
    return r;
  endfunction

  function automatic result_t payload_result(logic [7:0] b);
    result_t r;
    r                = '0;
    r.kind           = KIND_PAYLOAD;
    r.data_byte      = b;
    return r;
  endfunction

endpackage

@@ rtl/iframe_receive_deframer_core.sv @@
// I-frame receive deframer core: frame parser, destuffer and BCC check.
// Depends on ifrd_pkg.
//
// Takes one raw line byte per beat (in_valid_i / in_stall_o) and returns
// destuffed payload bytes and frame-end / disconnect events as result beats
// (out_valid_o / out_stall_i). Every accepted byte is parsed in the cycle it
// is taken and its zero, one or two results go into a four-entry result
// queue, so a byte can be taken every cycle while in_stall_o is low; the queue
// drains one result per cycle while out_stall_i is low; an escaped byte can
// release two results. in_stall_o is high while fewer than two queue entries
// are free. Writing cfg_wdata_i = 1 while the link is closed opens it
// (sequence reset, parser back to hunting for a flag); while it is 0
// accepted bytes are dropped with no result.
module iframe_receive_deframer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  // line bytes in
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  // results out
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic [7:0]                  data_byte_o,
  output logic [2:0]                  status_o,
  output logic                        reply_valid_o,
  output logic [7:0]                  reply_control_o,
  output logic [ifrd_pkg::LEN_W-1:0]  payload_length_o,
  output logic                        last_o
);

  localparam logic [2:0] PS_IDLE     = 3'd0;
  localparam logic [2:0] PS_GOT_FLAG = 3'd1;
  localparam logic [2:0] PS_GOT_ADDR = 3'd2;
  localparam logic [2:0] PS_GOT_CTRL = 3'd3;
  localparam logic [2:0] PS_DATA     = 3'd4;
  localparam logic [2:0] PS_DATA_ESC = 3'd5;

  localparam int unsigned QPTR_W = ifrd_pkg::QPTR_W;
  localparam int unsigned QCNT_W = ifrd_pkg::QCNT_W;

  logic                  link_q;
  logic [2:0]            ps_q, ps_d;
  logic                  frame_seq_q, frame_seq_d;
  logic                  exp_seq_q, exp_seq_d;
  ifrd_pkg::hold_t       hold_q, hold_d;

  ifrd_pkg::result_t     res0, res1;
  logic [1:0]            n_res;

  ifrd_pkg::result_t     queue_q [ifrd_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]     cnt_q, cnt_d;

  logic in_acc, step, pop;

  assign in_stall_o  = cnt_q > QCNT_W'(ifrd_pkg::QUEUE_DEPTH - 2);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign step        = in_acc & link_q;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o & ~out_stall_i;

  // parser step
  always_comb begin
    ifrd_pkg::hold_t   h1;
    ifrd_pkg::result_t ev;
    logic              good;
    logic              new_seq;

    ps_d        = ps_q;
    frame_seq_d = frame_seq_q;
    exp_seq_d   = exp_seq_q;
    hold_d      = hold_q;
    res0        = '0;
    res1        = '0;
    n_res       = 2'd0;
    h1          = hold_q;
    ev          = '0;
    good        = 1'b0;
    new_seq     = exp_seq_q;

    unique case (ps_q)
      PS_GOT_FLAG: begin
        if (rx_byte_i == ifrd_pkg::ADDR_SENDER) begin
          ps_d = PS_GOT_ADDR;
        end else if (rx_byte_i != ifrd_pkg::BYTE_FLAG) begin
          ps_d = PS_IDLE;
        end
      end
      PS_GOT_ADDR: begin
        if (rx_byte_i == ifrd_pkg::CTRL_SEQ0 || rx_byte_i == ifrd_pkg::CTRL_SEQ1) begin
          frame_seq_d = rx_byte_i == ifrd_pkg::CTRL_SEQ1;
          ps_d        = PS_GOT_CTRL;
        end else if (rx_byte_i == ifrd_pkg::BYTE_FLAG) begin
          ps_d = PS_GOT_FLAG;
        end else if (rx_byte_i == ifrd_pkg::CTRL_DISCONNECT) begin
          ev.kind          = ifrd_pkg::KIND_EVENT;
          ev.status        = ifrd_pkg::STATUS_DISCONNECT;
          ev.reply_valid   = 1'b1;
          ev.reply_control = ifrd_pkg::CTRL_DISCONNECT;
          ev.last          = 1'b1;
          res0             = ev;
          n_res            = 2'd1;
          ps_d             = PS_IDLE;
        end else begin
          ps_d = PS_IDLE;
        end
      end
      PS_GOT_CTRL: begin
        if (rx_byte_i == (ifrd_pkg::ADDR_SENDER ^
                          (frame_seq_q ? ifrd_pkg::CTRL_SEQ1 : ifrd_pkg::CTRL_SEQ0))) begin
          ps_d   = PS_DATA;
          hold_d = '0;
        end else if (rx_byte_i == ifrd_pkg::BYTE_FLAG) begin
          ps_d = PS_GOT_FLAG;
        end else begin
          ps_d = PS_IDLE;
        end
      end
      PS_DATA: begin
        if (rx_byte_i == ifrd_pkg::BYTE_ESCAPE) begin
          ps_d = PS_DATA_ESC;
        end else if (rx_byte_i == ifrd_pkg::BYTE_FLAG) begin
          ev.kind = ifrd_pkg::KIND_EVENT;
          ev.last = 1'b1;
          if (!hold_q.valid) begin
            ev.status = ifrd_pkg::STATUS_EMPTY;
          end else begin
            good              = hold_q.data == hold_q.bcc;
            ev.reply_valid    = 1'b1;
            ev.payload_length = hold_q.count;
            if (good && frame_seq_q == exp_seq_q) begin
              new_seq          = ~exp_seq_q;
              ev.status        = ifrd_pkg::STATUS_ACCEPTED;
              ev.reply_control = new_seq ? ifrd_pkg::CTRL_RR1 : ifrd_pkg::CTRL_RR0;
            end else if (!good) begin
              ev.status        = ifrd_pkg::STATUS_CHECK_ERR;
              ev.reply_control = exp_seq_q ? ifrd_pkg::CTRL_REJ1 : ifrd_pkg::CTRL_REJ0;
            end else begin
              ev.status        = ifrd_pkg::STATUS_DUPLICATE;
              ev.reply_control = exp_seq_q ? ifrd_pkg::CTRL_RR1 : ifrd_pkg::CTRL_RR0;
            end
          end
          exp_seq_d = new_seq;
          res0      = ev;
          n_res     = 2'd1;
          hold_d    = '0;
          hold_d.data = hold_q.data;
          ps_d      = PS_IDLE;
        end else begin
          if (hold_q.valid) begin
            res0      = ifrd_pkg::payload_result(hold_q.data);
            res0.last = 1'b1;
            n_res     = 2'd1;
          end
          hold_d = ifrd_pkg::hold_push(hold_q, rx_byte_i);
        end
      end
      PS_DATA_ESC: begin
        ps_d = PS_DATA;
        if (rx_byte_i != ifrd_pkg::BYTE_FLAG && rx_byte_i != ifrd_pkg::BYTE_ESCAPE) begin
          // escape kept as data: two pushes, the second always releases
          h1 = ifrd_pkg::hold_push(hold_q, ifrd_pkg::BYTE_ESCAPE);
          if (hold_q.valid) begin
            res0      = ifrd_pkg::payload_result(hold_q.data);
            res1      = ifrd_pkg::payload_result(ifrd_pkg::BYTE_ESCAPE);
            res1.last = 1'b1;
            n_res     = 2'd2;
          end else begin
            res0      = ifrd_pkg::payload_result(ifrd_pkg::BYTE_ESCAPE);
            res0.last = 1'b1;
            n_res     = 2'd1;
          end
          hold_d = ifrd_pkg::hold_push(h1, rx_byte_i);
        end else begin
          if (hold_q.valid) begin
            res0      = ifrd_pkg::payload_result(hold_q.data);
            res0.last = 1'b1;
            n_res     = 2'd1;
          end
          hold_d = ifrd_pkg::hold_push(hold_q, rx_byte_i);
        end
      end
      default: begin
        ps_d = (rx_byte_i == ifrd_pkg::BYTE_FLAG) ? PS_GOT_FLAG : PS_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (step) begin
      cnt_d = cnt_d + QCNT_W'(n_res);
    end
    if (pop) begin
      cnt_d = cnt_d - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= 1'b0;
      ps_q        <= PS_IDLE;
      frame_seq_q <= 1'b0;
      exp_seq_q   <= 1'b0;
      hold_q      <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (step) begin
        frame_seq_q <= frame_seq_d;
        hold_q      <= hold_d;
        wr_ptr_q    <= wr_ptr_q + QPTR_W'(n_res);
      end
      // opening the link restarts the parser and the sequence
      if (cfg_we_i && cfg_wdata_i && !link_q) begin
        exp_seq_q <= 1'b0;
        ps_q      <= PS_IDLE;
      end else if (step) begin
        ps_q      <= ps_d;
        exp_seq_q <= exp_seq_d;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        link_q <= cfg_wdata_i;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (step && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (step && n_res == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
    end
  end

  ifrd_pkg::result_t head;
  assign head = queue_q[rd_ptr_q];

  assign kind_o           = head.kind;
  assign data_byte_o      = head.data_byte;
  assign status_o         = head.status;
  assign reply_valid_o    = head.reply_valid;
  assign reply_control_o  = head.reply_control;
  assign payload_length_o = head.payload_length;
  assign last_o           = head.last;

endmodule

@@ sim/tb_iframe_receive_deframer_core.sv @@
// Self-checking testbench for iframe_receive_deframer_core: drives line bytes, predicts
// the payload, frame-end and disconnect beats in step with the DUT and checks them in order.
// Depends on ifrd_pkg and iframe_receive_deframer_core.
`timescale 1ns / 1ps

module tb_iframe_receive_deframer_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_MAX     = 10;

  typedef enum logic [2:0] {
    HUNT, SAW_FLAG, SAW_ADDR, SAW_CTRL, IN_DATA, IN_ESC
  } rx_phase_e;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic                          cfg_wdata_i = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    rx_byte_i   = 8'h00;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          kind_o;
  logic [7:0]                    data_byte_o;
  logic [2:0]                    status_o;
  logic                          reply_valid_o;
  logic [7:0]                    reply_control_o;
  logic [ifrd_pkg::LEN_W-1:0]    payload_length_o;
  logic                          last_o;

  iframe_receive_deframer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .status_o         (status_o),
    .reply_valid_o    (reply_valid_o),
    .reply_control_o  (reply_control_o),
    .payload_length_o (payload_length_o),
    .last_o           (last_o)
  );

  // deframer shadow state
  rx_phase_e                  phase     = HUNT;
  logic                       link_on   = 1'b0;
  logic                       frame_seq = 1'b0;
  logic                       next_seq  = 1'b0;
  logic [7:0]                 bcc_acc   = 8'h00;
  logic [7:0]                 held      = 8'h00;
  logic                       held_ok   = 1'b0;
  logic [ifrd_pkg::LEN_W-1:0] body_len  = '0;
  ifrd_pkg::result_t          results_due[$];

  logic [7:0]       tx_bytes[$];
  logic [7:0]       frame_body[$];
  int               bytes_queued    = 0;
  logic             steady          = 1'b0;
  logic             line_beat_taken = 1'b0;
  int               bad_beats       = 0;
  int               idle_cycles     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- prediction ----------------

  function automatic void apply_link(logic v);
    if (v && !link_on) begin
      next_seq = 1'b0;
      phase    = HUNT;
    end
    link_on = v;
  endfunction

  function automatic void post_event(logic [2:0] st, logic rv, logic [7:0] rc,
                                     logic [ifrd_pkg::LEN_W-1:0] len);
    ifrd_pkg::result_t r;
    r                = '0;
    r.kind           = ifrd_pkg::KIND_EVENT;
    r.status         = st;
    r.reply_valid    = rv;
    r.reply_control  = rc;
    r.payload_length = len;
    results_due.push_back(r);
  endfunction

  // payload leaves one byte late, so the check byte is never released
  function automatic void release_byte(logic [7:0] b);
    ifrd_pkg::result_t r;
    if (held_ok) begin
      r           = '0;
      r.kind      = ifrd_pkg::KIND_PAYLOAD;
      r.data_byte = held;
      results_due.push_back(r);
      bcc_acc = bcc_acc ^ held;
      if (body_len < ifrd_pkg::LEN_W'(ifrd_pkg::MAX_PAYLOAD))
        body_len = body_len + ifrd_pkg::LEN_W'(1);
    end
    held    = b;
    held_ok = 1'b1;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int                n_prior;
    ifrd_pkg::result_t tail;
    n_prior = results_due.size();
    if (!link_on) return;
    case (phase)
      SAW_FLAG: begin
        if (b == ifrd_pkg::ADDR_SENDER) phase = SAW_ADDR;
        else if (b != ifrd_pkg::BYTE_FLAG) phase = HUNT;
      end
      SAW_ADDR: begin
        if (b == ifrd_pkg::CTRL_SEQ0 || b == ifrd_pkg::CTRL_SEQ1) begin
          frame_seq = (b == ifrd_pkg::CTRL_SEQ1);
          phase     = SAW_CTRL;
        end else if (b == ifrd_pkg::BYTE_FLAG) begin
          phase = SAW_FLAG;
        end else if (b == ifrd_pkg::CTRL_DISCONNECT) begin
          post_event(ifrd_pkg::STATUS_DISCONNECT, 1'b1, ifrd_pkg::CTRL_DISCONNECT, '0);
          phase = HUNT;
        end else begin
          phase = HUNT;
        end
      end
      SAW_CTRL: begin
        if (b == (ifrd_pkg::ADDR_SENDER ^
                  (frame_seq ? ifrd_pkg::CTRL_SEQ1 : ifrd_pkg::CTRL_SEQ0))) begin
          phase    = IN_DATA;
          bcc_acc  = 8'h00;
          held     = 8'h00;
          held_ok  = 1'b0;
          body_len = '0;
        end else if (b == ifrd_pkg::BYTE_FLAG) begin
          phase = SAW_FLAG;
        end else begin
          phase = HUNT;
        end
      end
      IN_DATA: begin
        if (b == ifrd_pkg::BYTE_ESCAPE) begin
          phase = IN_ESC;
        end else if (b == ifrd_pkg::BYTE_FLAG) begin
          if (!held_ok) begin
            post_event(ifrd_pkg::STATUS_EMPTY, 1'b0, 8'h00, '0);
          end else if (held == bcc_acc && frame_seq == next_seq) begin
            next_seq = ~next_seq;
            post_event(ifrd_pkg::STATUS_ACCEPTED, 1'b1,
                       next_seq ? ifrd_pkg::CTRL_RR1 : ifrd_pkg::CTRL_RR0, body_len);
          end else if (held != bcc_acc) begin
            post_event(ifrd_pkg::STATUS_CHECK_ERR, 1'b1,
                       next_seq ? ifrd_pkg::CTRL_REJ1 : ifrd_pkg::CTRL_REJ0, body_len);
          end else begin
            post_event(ifrd_pkg::STATUS_DUPLICATE, 1'b1,
                       next_seq ? ifrd_pkg::CTRL_RR1 : ifrd_pkg::CTRL_RR0, body_len);
          end
          held_ok  = 1'b0;
          bcc_acc  = 8'h00;
          body_len = '0;
          phase    = HUNT;
        end else begin
          release_byte(b);
        end
      end
      IN_ESC: begin
        phase = IN_DATA;
        if (b != ifrd_pkg::BYTE_FLAG && b != ifrd_pkg::BYTE_ESCAPE)
          release_byte(ifrd_pkg::BYTE_ESCAPE);
        release_byte(b);
      end
      default: phase = (b == ifrd_pkg::BYTE_FLAG) ? SAW_FLAG : HUNT;
    endcase
    if (results_due.size() > n_prior) begin
      tail      = results_due.pop_back();
      tail.last = 1'b1;
      results_due.push_back(tail);
    end
  endfunction

  function automatic string show(ifrd_pkg::result_t r);
    return $sformatf("kind=%0d data=%02h status=%0d rv=%0d rc=%02h len=%0d last=%0d",
                     r.kind, r.data_byte, r.status, r.reply_valid, r.reply_control,
                     r.payload_length, r.last);
  endfunction

  // ---------------- driver ----------------

  always @(negedge clk_i) begin
    if (!in_valid_i || line_beat_taken) begin
      if (rst_ni && tx_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        rx_byte_i  <= tx_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !steady && ($urandom_range(0, 99) < 25);
  end

  // ---------------- monitor ----------------

  always @(posedge clk_i) begin : monitor
    ifrd_pkg::result_t got;
    ifrd_pkg::result_t want;
    logic              result_taken;
    if (rst_ni) begin
      if (cfg_we_i) apply_link(cfg_wdata_i);
      line_beat_taken = in_valid_i && !in_stall_o;
      if (line_beat_taken) deframe_byte(rx_byte_i);
      result_taken = out_valid_o && !out_stall_i;
      if (result_taken) begin
        got.kind           = kind_o;
        got.data_byte      = data_byte_o;
        got.status         = status_o;
        got.reply_valid    = reply_valid_o;
        got.reply_control  = reply_control_o;
        got.payload_length = payload_length_o;
        got.last           = last_o;
        if (results_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= REPORT_MAX)
            $display("%0t: unexpected result beat: %s", $time, show(got));
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.status !== want.status || got.reply_valid !== want.reply_valid ||
              got.reply_control !== want.reply_control ||
              got.payload_length !== want.payload_length || got.last !== want.last) begin
            bad_beats++;
            if (bad_beats <= REPORT_MAX)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $time, show(want), show(got));
          end
        end
      end
      idle_cycles = (line_beat_taken || result_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic void put(logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // biased toward the flag and escape codes
  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 7))
      0:       return ifrd_pkg::BYTE_FLAG;
      1:       return ifrd_pkg::BYTE_ESCAPE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void send_header(logic seq);
    put(ifrd_pkg::BYTE_FLAG);
    put(ifrd_pkg::ADDR_SENDER);
    put(seq ? ifrd_pkg::CTRL_SEQ1 : ifrd_pkg::CTRL_SEQ0);
    put(ifrd_pkg::ADDR_SENDER ^ (seq ? ifrd_pkg::CTRL_SEQ1 : ifrd_pkg::CTRL_SEQ0));
  endfunction

  // sends frame_body stuffed, with its check byte, then clears it
  function automatic void send_frame(logic seq, logic corrupt);
    logic [7:0] chk;
    logic [7:0] raw[$];
    chk = 8'h00;
    foreach (frame_body[i]) chk ^= frame_body[i];
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    raw = frame_body;
    raw.push_back(chk);
    send_header(seq);
    foreach (raw[i]) begin
      if (raw[i] == ifrd_pkg::BYTE_FLAG) begin
        put(ifrd_pkg::BYTE_ESCAPE);
        put(ifrd_pkg::BYTE_FLAG);
      end else if (raw[i] == ifrd_pkg::BYTE_ESCAPE) begin
        put(ifrd_pkg::BYTE_ESCAPE);
        // a bare escape before an ordinary byte decodes to both bytes
        if (!(i + 1 < raw.size() && raw[i+1] != ifrd_pkg::BYTE_FLAG &&
              raw[i+1] != ifrd_pkg::BYTE_ESCAPE && $urandom_range(0, 3) != 0))
          put(ifrd_pkg::BYTE_ESCAPE);
      end else begin
        put(raw[i]);
      end
    end
    put(ifrd_pkg::BYTE_FLAG);
    frame_body.delete();
  endfunction

  function automatic void random_traffic(int n);
    int target;
    int len;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          repeat (len) frame_body.push_back(line_byte());
          send_frame(1'($urandom_range(0, 1)), 1'b0);
        end
        11, 12: begin
          repeat ($urandom_range(0, 6)) frame_body.push_back(line_byte());
          send_frame(1'($urandom_range(0, 1)), 1'b1);
        end
        13: begin
          send_header(1'($urandom_range(0, 1)));
          put(ifrd_pkg::BYTE_FLAG);
        end
        14: begin
          put(ifrd_pkg::BYTE_FLAG);
          put(ifrd_pkg::ADDR_SENDER);
          put(ifrd_pkg::CTRL_DISCONNECT);
        end
        15, 16: begin
          // broken header
          put(ifrd_pkg::BYTE_FLAG);
          if ($urandom_range(0, 1)) put(ifrd_pkg::ADDR_SENDER);
          repeat ($urandom_range(1, 2)) put(line_byte());
        end
        17: begin
          // frame cut short; the next flag closes it
          send_header(1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 4)) put(line_byte());
        end
        default: repeat ($urandom_range(1, 4)) put(8'($urandom));
      endcase
    end
  endfunction

  task automatic wait_quiet();
    do begin
      @(posedge clk_i);
      #1;
    end while (tx_bytes.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_link(logic v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // link closed: bytes are taken and dropped
    write_link(1'b0);
    put(ifrd_pkg::BYTE_FLAG); put(ifrd_pkg::ADDR_SENDER); put(ifrd_pkg::CTRL_DISCONNECT);
    put(8'hFF); put(8'h00);
    wait_quiet();
    write_link(1'b1);

    // directed frames
    send_header(1'b0);
    put(ifrd_pkg::BYTE_FLAG);
    frame_body = '{8'h00, 8'hFF};
    send_frame(1'b0, 1'b0);
    frame_body = '{ifrd_pkg::BYTE_FLAG, ifrd_pkg::BYTE_ESCAPE, 8'h41};
    send_frame(1'b1, 1'b0);
    frame_body = '{8'h55};
    send_frame(1'b1, 1'b0);
    frame_body = '{8'h12, 8'h34};
    send_frame(1'b0, 1'b1);
    put(ifrd_pkg::BYTE_FLAG); put(ifrd_pkg::ADDR_SENDER); put(ifrd_pkg::CTRL_DISCONNECT);
    put(ifrd_pkg::BYTE_FLAG);
    frame_body = '{8'hAA};
    send_frame(1'b0, 1'b0);
    put(ifrd_pkg::BYTE_FLAG); put(ifrd_pkg::ADDR_SENDER);
    send_frame(1'b1, 1'b0);
    put(ifrd_pkg::BYTE_FLAG); put(ifrd_pkg::ADDR_SENDER); put(ifrd_pkg::CTRL_SEQ1);
    send_frame(1'b0, 1'b0);
    put(ifrd_pkg::BYTE_FLAG); put(8'h01);
    put(ifrd_pkg::BYTE_FLAG); put(ifrd_pkg::ADDR_SENDER); put(8'h22);
    put(ifrd_pkg::BYTE_FLAG); put(ifrd_pkg::ADDR_SENDER); put(ifrd_pkg::CTRL_SEQ1);
    put(ifrd_pkg::ADDR_SENDER);
    wait_quiet();

    // opening an open link keeps the sequence state
    write_link(1'b1);
    random_traffic(150);
    wait_quiet();

    steady = 1'b1;
    random_traffic(100);
    wait_quiet();
    steady = 1'b0;

    write_link(1'b0);
    repeat (10) put(line_byte());
    wait_quiet();
    write_link(1'b1);
    random_traffic(110);
    wait_quiet();

    repeat (20) @(posedge clk_i);
    if (bad_beats == 0 && results_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
